[rtl/core/cdar_pkg.sv]
// Package: shared types, opcodes and constants for the congestion detector.
`timescale 1ns / 1ps
`default_nettype none
package cdar_pkg;

    localparam int unsigned NEIGHBOR_SLOTS_DEF = 16;
    localparam int unsigned CNT_W = 16;
    localparam int unsigned CFG_W = 8;
    localparam int unsigned PROD_W = CNT_W + CFG_W;
    localparam int unsigned IDX_W = 4;

    typedef enum logic [2:0] {
        OP_RX      = 3'd0,
        OP_TX      = 3'd1,
        OP_REPORT  = 3'd2,
        OP_REQUEST = 3'd3,
        OP_NBR_WR  = 3'd4,
        OP_NOTICE  = 3'd5,
        OP_TICK    = 3'd6,
        OP_PARENT  = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        CFG_LOW   = 2'd0,
        CFG_HIGH  = 2'd1,
        CFG_SCALE = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_DIV_LO,
        ST_MUL_HI,
        ST_DIV_HI,
        ST_SCAN_TICK,
        ST_SCAN_ALT,
        ST_OUT
    } state_t;

    // Request and reply between sequencer and shared divider
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [CFG_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

[rtl/core/cdar_divider.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module cdar_divider
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cdar_pkg::div_req_t req,
    output cdar_pkg::div_rsp_t    rsp
);
    import cdar_pkg::*;

    localparam int unsigned CNT_BITS = $clog2(PROD_W + 1);

    logic [PROD_W-1:0]   quo_reg, quo_next;
    logic [CFG_W:0]      rem_reg, rem_next;
    logic [CFG_W-1:0]    dvs_reg, dvs_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CFG_W+1:0]    trial;

    // Load operands on start, else advance one quotient bit
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[PROD_W-1]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = (req.divisor == '0) ? CFG_W'(1) : req.divisor;
            cnt_next  = CNT_BITS'(PROD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {2'b00, dvs_reg})
            begin
                rem_next = (CFG_W+1)'(trial - {2'b00, dvs_reg});
                quo_next = {quo_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[CFG_W:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold divider state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule
`default_nettype wire

[rtl/core/congestion_detect_alt_route.sv]
// Top level: congestion detector and alternate route selector.
//
// Channel   | Dir | Handshake        | Payload
// s_axis    | in  | tvalid/tready    | tdata: op, report_value, neighbor_index,
//           |     |                  |        entry_valid, entry_is_parent,
//           |     |                  |        entry_congested
// m_axis    | out | tvalid/tready    | tdata: report_count, is_congested, ...
// cfg       | in  | cfg_valid/ready  | cfg_index, cfg_data
//
// Simple ops pass from idle through the output state, which loads the result
// register. A tick runs the two band divisions through the shared divider,
// then walks every slot and loads the result. A notice walks the slots up to
// the first uncongested candidate, then loads the result.
// The input side stays not ready from accept until the result is taken.
// Reset clears all counters, the neighbor table and route state.
`timescale 1ns / 1ps
`default_nettype none
module congestion_detect_alt_route
#(
    parameter int unsigned NEIGHBOR_SLOTS = cdar_pkg::NEIGHBOR_SLOTS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // op[2:0], report_value[18:3], neighbor_index[22:19], entry_valid[23],
    // entry_is_parent[24], entry_congested[25], zero fill [31:26]
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // report_count[15:0], is_congested[16], multipath_active[17],
    // alt_found[18], alt_slot[22:19], route_added[23], route_removed[24],
    // zero fill [31:25]
    output logic [31:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import cdar_pkg::*;

    localparam int unsigned SLOT_W = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
    localparam int unsigned TOT_W  = $clog2(NEIGHBOR_SLOTS + 1);

    state_t state_reg, state_next;

    logic [CFG_W-1:0] low_reg, high_reg, scale_reg;
    logic [CNT_W-1:0] rx_reg, exp_reg, sent_reg;
    logic [NEIGHBOR_SLOTS-1:0] vld_reg, par_reg, cng_reg;
    logic [IDX_W-1:0] pref_reg, alt_reg;
    logic pref_present_reg, mp_reg, alt_held_reg, cong_reg;

    // Latched input word
    logic [2:0]       op_reg;
    logic [CNT_W-1:0] rep_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             ev_reg, ep_reg, ec_reg;

    // Tick and walk working registers
    logic [PROD_W-1:0] lo_reg;
    logic              out_band_reg;
    logic [SLOT_W:0]   scan_reg;
    logic [TOT_W-1:0]  total_reg, busy_reg;
    logic              have_reg, found_reg;
    logic [IDX_W-1:0]  pick_reg;
    logic              mul_lo_go;

    logic [31:0]       out_reg;
    logic              out_vld_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    logic accept;
    logic idx_ok;
    logic [SLOT_W-1:0] scan_idx;
    logic scan_last;
    logic pref_in_range;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && !out_vld_reg;
    assign cfg_ready     = 1'b1;
    assign idx_ok        = {28'd0, idx_reg} < 32'(NEIGHBOR_SLOTS);
    assign scan_idx      = scan_reg[SLOT_W-1:0];
    assign scan_last     = scan_reg == (SLOT_W+1)'(NEIGHBOR_SLOTS - 1);
    assign pref_in_range = {28'd0, pref_reg} < 32'(NEIGHBOR_SLOTS);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg;

    cdar_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign mul_lo_go = (state_reg == ST_MUL_LO);
    always_comb
    begin
        dreq.start    = (state_reg == ST_MUL_LO) || (state_reg == ST_MUL_HI);
        dreq.dividend = mul_lo_go ? exp_reg * low_reg : exp_reg * high_reg;
        dreq.divisor  = scale_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op_t'(s_axis_tdata[2:0]) == OP_TICK)
                        state_next = ST_MUL_LO;
                    else if (op_t'(s_axis_tdata[2:0]) == OP_NOTICE)
                        state_next = ST_SCAN_ALT;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_MUL_LO:    state_next = ST_DIV_LO;
            ST_DIV_LO:    if (drsp.done) state_next = ST_MUL_HI;
            ST_MUL_HI:    state_next = ST_DIV_HI;
            ST_DIV_HI:    if (drsp.done) state_next = ST_SCAN_TICK;
            ST_SCAN_TICK: if (scan_last) state_next = ST_OUT;
            ST_SCAN_ALT:  if (scan_last || found_reg) state_next = ST_OUT;
            ST_OUT:       state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= s_axis_tdata[2:0];
            rep_reg <= s_axis_tdata[18:3];
            idx_reg <= s_axis_tdata[22:19];
            ev_reg  <= s_axis_tdata[23];
            ep_reg  <= s_axis_tdata[24];
            ec_reg  <= s_axis_tdata[25];
        end
    end

    // Apply config writes, execute ops, walk slots, build result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg <= CFG_W'(50);
            high_reg <= CFG_W'(150);
            scale_reg <= CFG_W'(100);
            rx_reg <= '0; exp_reg <= '0; sent_reg <= '0;
            vld_reg <= '0; par_reg <= '0; cng_reg <= '0;
            pref_reg <= '0; alt_reg <= '0;
            pref_present_reg <= 1'b0; mp_reg <= 1'b0;
            alt_held_reg <= 1'b0; cong_reg <= 1'b0;
            out_vld_reg <= 1'b0; out_reg <= '0;
            lo_reg <= '0; out_band_reg <= 1'b0;
            scan_reg <= '0; total_reg <= '0; busy_reg <= '0;
            have_reg <= 1'b0; found_reg <= 1'b0; pick_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_LOW:   low_reg <= cfg_data;
                    CFG_HIGH:  high_reg <= cfg_data;
                    CFG_SCALE: scale_reg <= cfg_data;
                    default:   ;
                endcase
            end
            if (m_axis_tready && out_vld_reg)
                out_vld_reg <= 1'b0;
            if (accept)
            begin
                scan_reg <= '0; total_reg <= '0; busy_reg <= '0;
                have_reg <= 1'b0; found_reg <= 1'b0;
            end
            if (state_reg == ST_DIV_LO && drsp.done)
                lo_reg <= drsp.quotient;
            if (state_reg == ST_DIV_HI && drsp.done)
                out_band_reg <= ({8'd0, rx_reg} < lo_reg) ||
                                ({8'd0, rx_reg} > drsp.quotient);
            if (state_reg == ST_SCAN_TICK)
            begin
                scan_reg <= scan_reg + 1'b1;
                if (vld_reg[scan_idx])
                begin
                    total_reg <= total_reg + 1'b1;
                    busy_reg  <= busy_reg + TOT_W'(cng_reg[scan_idx]);
                end
            end
            if (state_reg == ST_SCAN_ALT && !found_reg)
            begin
                scan_reg <= scan_reg + 1'b1;
                if (vld_reg[scan_idx] && par_reg[scan_idx] &&
                    !(pref_present_reg && IDX_W'(scan_idx) == pref_reg))
                begin
                    have_reg <= 1'b1;
                    pick_reg <= IDX_W'(scan_idx);
                    if (!cng_reg[scan_idx])
                        found_reg <= 1'b1;
                end
            end
            if (state_reg == ST_OUT)
            begin
                logic [CNT_W-1:0] rep;
                logic add_r, rem_r, mp_n, held_n, cong_n;
                logic [IDX_W-1:0] alt_n;
                rep = '0; add_r = 1'b0; rem_r = 1'b0;
                mp_n = mp_reg; held_n = alt_held_reg; alt_n = alt_reg;
                cong_n = cong_reg;
                case (op_t'(op_reg))
                    OP_RX:      rx_reg <= rx_reg + 1'b1;
                    OP_TX:      sent_reg <= sent_reg + 1'b1;
                    OP_REPORT:  exp_reg <= exp_reg + rep_reg;
                    OP_REQUEST:
                    begin
                        rep = sent_reg;
                        sent_reg <= '0;
                    end
                    OP_NBR_WR:
                    begin
                        if (idx_ok)
                        begin
                            vld_reg[SLOT_W'(idx_reg)] <= ev_reg;
                            par_reg[SLOT_W'(idx_reg)] <= ep_reg;
                            cng_reg[SLOT_W'(idx_reg)] <= ec_reg;
                        end
                    end
                    OP_NOTICE:
                    begin
                        if (idx_ok && !mp_reg && pref_present_reg &&
                            idx_reg == pref_reg && have_reg)
                        begin
                            alt_n = pick_reg; held_n = 1'b1;
                            mp_n = 1'b1; add_r = 1'b1;
                        end
                    end
                    OP_TICK:
                    begin
                        cong_n = out_band_reg ||
                                 ({1'b0, total_reg} < {busy_reg, 1'b0});
                        if (pref_present_reg && pref_in_range &&
                            !cng_reg[SLOT_W'(pref_reg)])
                        begin
                            mp_n = 1'b0;
                            if (alt_held_reg)
                            begin
                                held_n = 1'b0; alt_n = '0; rem_r = 1'b1;
                            end
                        end
                        rx_reg <= '0; exp_reg <= '0;
                    end
                    default:
                    begin
                        if (idx_ok)
                        begin
                            pref_reg <= idx_reg;
                            pref_present_reg <= ev_reg;
                        end
                    end
                endcase
                mp_reg <= mp_n; alt_held_reg <= held_n; alt_reg <= alt_n;
                cong_reg <= cong_n;
                out_reg <= {7'd0, rem_r, add_r, held_n ? alt_n : 4'd0,
                            held_n, mp_n, cong_n, rep};
                out_vld_reg <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire
